[src/u8d_pkg.sv]
// shared types, constants and helpers of the utf-8 stream decoder
package u8d_pkg;

    // default number of decoded jobs buffered between front and back
    localparam int U8D_QUEUE_DEPTH = 4;

    localparam logic [20:0] ESC_BASE  = 21'h00DC00;
    localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;

    // one job: escapes of the held bytes, then an optional tail result
    typedef struct packed {
        logic [1:0]      held_n;
        logic [2:0][7:0] held;
        logic            has_tail;
        logic [20:0]     tail_cp;
        logic            tail_esc;
    } t_job;

    // escape value for an undecodable byte
    function automatic logic [20:0] escape_of(input logic [7:0] b);
        escape_of = ESC_BASE | {13'd0, b};
    endfunction

endpackage

[src/u8d_front.sv]
// front part: accepts bytes, tracks the open sequence and builds result jobs
module u8d_front import u8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_input,
    output logic        o_job_push,
    output t_job        o_job
);

    logic [1:0]      r_be, n_be;
    logic [20:0]     r_pv, n_pv;
    logic [1:0]      r_sl, n_sl;
    logic [2:0][7:0] r_hb, n_hb;
    logic [1:0]      r_hc, n_hc;

    logic        st_emit;
    logic        st_lead;
    logic [20:0] st_cp;
    logic        st_esc;
    logic [1:0]  st_len;
    logic [20:0] st_val;
    logic        is_cont;
    logic [20:0] pv_acc;
    logic [20:0] min_val;
    logic        bad;

    // classify the byte as it would be seen from the initial state
    always_comb begin
        st_emit = 1'b1;
        st_lead = 1'b0;
        st_cp   = escape_of(i_byte_value);
        st_esc  = 1'b1;
        st_len  = 2'd0;
        st_val  = 21'd0;
        if (i_byte_value < 8'h80) begin
            st_cp  = {13'd0, i_byte_value};
            st_esc = 1'b0;
        end else if (i_byte_value >= 8'hC0 && i_byte_value < 8'hE0) begin
            st_emit = 1'b0;
            st_lead = 1'b1;
            st_len  = 2'd1;
            st_val  = {16'd0, i_byte_value[4:0]};
        end else if (i_byte_value >= 8'hE0 && i_byte_value < 8'hF0) begin
            st_emit = 1'b0;
            st_lead = 1'b1;
            st_len  = 2'd2;
            st_val  = {17'd0, i_byte_value[3:0]};
        end else if (i_byte_value >= 8'hF0 && i_byte_value < 8'hF5) begin
            st_emit = 1'b0;
            st_lead = 1'b1;
            st_len  = 2'd3;
            st_val  = {18'd0, i_byte_value[2:0]};
        end
    end

    // continuation accumulate and final value check
    always_comb begin
        is_cont = (i_byte_value[7:6] == 2'b10);
        pv_acc  = {r_pv[14:0], i_byte_value[5:0]};
        case (r_sl)
            2'd1:    min_val = MIN_TWO;
            2'd2:    min_val = MIN_THREE;
            default: min_val = MIN_FOUR;
        endcase
        bad = (pv_acc < min_val) ||
              (pv_acc[20:16] == 5'd0 && pv_acc[15:8] == ESC_BASE[15:8]) ||
              (pv_acc > MAX_CODE);
    end

    // sequence state update and job construction
    always_comb begin
        n_be  = r_be;
        n_pv  = r_pv;
        n_sl  = r_sl;
        n_hb  = r_hb;
        n_hc  = r_hc;
        o_job_push     = 1'b0;
        o_job.held_n   = 2'd0;
        o_job.held     = r_hb;
        o_job.has_tail = 1'b0;
        o_job.tail_cp  = st_cp;
        o_job.tail_esc = st_esc;
        if (i_accept) begin
            if (i_end_of_input) begin
                if (r_be != 2'd0) begin
                    o_job_push   = 1'b1;
                    o_job.held_n = r_hc;
                    n_be = 2'd0;
                    n_pv = 21'd0;
                    n_sl = 2'd0;
                    n_hc = 2'd0;
                end
            end else if (r_be == 2'd0 || !is_cont) begin
                // fail any open sequence, then decode the byte afresh
                o_job_push     = st_emit || (r_be != 2'd0);
                o_job.held_n   = (r_be != 2'd0) ? r_hc : 2'd0;
                o_job.has_tail = st_emit;
                n_be = 2'd0;
                n_pv = 21'd0;
                n_sl = 2'd0;
                n_hc = 2'd0;
                if (st_lead) begin
                    n_be    = st_len;
                    n_sl    = st_len;
                    n_pv    = st_val;
                    n_hb[0] = i_byte_value;
                    n_hc    = 2'd1;
                end
            end else if (r_be == 2'd1) begin
                // sequence completes with this continuation
                o_job_push     = 1'b1;
                o_job.has_tail = 1'b1;
                if (bad) begin
                    o_job.held_n = r_hc;
                end else begin
                    o_job.tail_cp  = pv_acc;
                    o_job.tail_esc = 1'b0;
                end
                n_be = 2'd0;
                n_pv = 21'd0;
                n_sl = 2'd0;
                n_hc = 2'd0;
            end else begin
                n_pv = pv_acc;
                n_be = r_be - 2'd1;
                if (r_hc < 2'd3) begin
                    n_hb[r_hc] = i_byte_value;
                    n_hc       = r_hc + 2'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_be <= 2'd0;
            r_pv <= 21'd0;
            r_sl <= 2'd0;
            r_hc <= 2'd0;
        end else begin
            r_be <= n_be;
            r_pv <= n_pv;
            r_sl <= n_sl;
            r_hc <= n_hc;
        end
    end

    // held bytes need no reset
    always_ff @(posedge i_clk) begin
        r_hb <= n_hb;
    end

    // an open sequence always holds its lead byte, the initial state holds none
    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_be == 2'd0) |-> (r_hc == 2'd0 && r_sl == 2'd0))
        else $error("held bytes left in initial state");
    a_open_has_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_be != 2'd0) |-> (r_hc != 2'd0 && r_be <= r_sl))
        else $error("open sequence without lead byte");

endmodule

[src/u8d_queue.sv]
// short job queue between the front and the back part
module u8d_queue import u8d_pkg::*; #(
    parameter int DEPTH = U8D_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // the front only pushes on accepted items, which full already blocks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

[src/u8d_back.sv]
// back part: walks each job and delivers one result per cycle while the receiver keeps popping
module u8d_back import u8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_head_valid,
    output logic        o_head_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [20:0] o_code_point,
    output logic        o_is_escape,
    output logic        o_last_of_run
);

    logic        r_ov;
    logic [1:0]  r_idx;
    logic [20:0] r_cp;
    logic        r_esc;
    logic        r_last;

    logic        load;
    logic [2:0]  total;
    logic        last;
    logic [20:0] sel_cp;
    logic        sel_esc;

    // pick the result at the current index of the head job
    always_comb begin
        load  = i_head_valid && (!r_ov || i_pop);
        total = {1'b0, i_head.held_n} + {2'd0, i_head.has_tail};
        last  = (({1'b0, r_idx} + 3'd1) == total);
        if (r_idx < i_head.held_n) begin
            sel_cp  = escape_of(i_head.held[r_idx]);
            sel_esc = 1'b1;
        end else begin
            sel_cp  = i_head.tail_cp;
            sel_esc = i_head.tail_esc;
        end
    end

    assign o_head_pop    = load && last;
    assign o_empty       = !r_ov;
    assign o_code_point  = r_cp;
    assign o_is_escape   = r_esc;
    assign o_last_of_run = r_last;

    // output valid and job index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else if (load) begin
            r_ov  <= 1'b1;
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= sel_cp;
            r_esc  <= sel_esc;
            r_last <= last;
        end
    end

    // a job being walked stays at the head of the queue
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_head_valid)
        else $error("job left queue before its last result");
    // the front never queues a job without results
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (total != 3'd0 && {1'b0, r_idx} < total))
        else $error("empty or overrun job at queue head");

endmodule

[src/utf8_stream_decoder.sv]
// top level of the utf-8 stream decoder
//
// Input queue side: drive push with i_byte_value or i_end_of_input; a
// transaction takes place at a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result sits on
// o_code_point, o_is_escape and o_last_of_run; a transaction takes place at
// a clock edge with pop high and empty low.
// Each byte gives zero to four results; o_last_of_run marks the final one.
// A lead byte gives nothing until its sequence ends; a failed sequence gives
// an escape for each held byte and then the result of the current byte.
// The first result of a byte goes into the job queue, then into the output register.
// Throughput: one byte per cycle while full is low and one result per cycle
// while pop is high; a byte that fails a sequence holds the back until all
// of its results are out, and full rises once QUEUE_DEPTH jobs wait.
// When the receiver stalls, results and jobs stay put and full rises once
// the job queue is full; bytes keep being taken until then.
// Reset (synchronous, active low) empties the queue and the output stage and
// returns the decoder to the initial state.
module utf8_stream_decoder import u8d_pkg::*; #(
    parameter int QUEUE_DEPTH = U8D_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_point,
    output logic        o_is_escape,
    output logic        o_last_of_run
);

    logic q_full;
    logic q_empty;
    logic job_push;
    logic head_pop;
    t_job job;
    t_job head;

    assign full = q_full;

    // front: classify bytes and build jobs
    u8d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push && !q_full),
        .i_byte_value   (i_byte_value),
        .i_end_of_input (i_end_of_input),
        .o_job_push     (job_push),
        .o_job          (job)
    );

    // job queue
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .i_pop   (head_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // back: deliver results
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (!q_empty),
        .o_head_pop    (head_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_code_point  (o_code_point),
        .o_is_escape   (o_is_escape),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[dv/tb_utf8_stream_decoder.sv]
// testbench of the utf-8 stream decoder: directed and random byte streams checked against a built-in decoder
`timescale 1ns / 1ps

module tb_utf8_stream_decoder import u8d_pkg::*; ();

    localparam int CYCLE_LIMIT = 50000;

    // one decoded code point as it leaves the block
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_escape;
        logic        last_of_run;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] o_code_point;
    logic        o_is_escape;
    logic        o_last_of_run;

    // decoder state mirrored by the testbench
    logic [1:0]  cont_left = 2'd0;
    logic [20:0] accum = 21'd0;
    logic [1:0]  seq_len = 2'd0;
    logic [7:0]  held_seq [3];
    logic [1:0]  held_n = 2'd0;

    t_decoded    pending_points [$];
    t_decoded    oldest_point;
    int          error_count = 0;
    int          cycle_count = 0;
    int          pop_hold = 0;
    bit          steady = 1'b0;

    utf8_stream_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_byte_value   (i_byte_value),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_code_point   (o_code_point),
        .o_is_escape    (o_is_escape),
        .o_last_of_run  (o_last_of_run)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[utf8_stream_decoder] ERROR");
            $finish;
        end
    end

    // queue one expected result
    function automatic void emit_point(input logic [20:0] cp, input logic esc);
        t_decoded item;
        item.code_point = cp;
        item.is_escape = esc;
        item.last_of_run = 1'b0;
        pending_points.push_back(item);
    endfunction

    function automatic void clear_sequence();
        cont_left = 2'd0;
        accum = 21'd0;
        seq_len = 2'd0;
        held_n = 2'd0;
    endfunction

    // byte seen in the initial state: pass, escape or open a sequence
    function automatic void open_or_emit(input logic [7:0] b);
        if (b < 8'h80) begin
            emit_point({13'd0, b}, 1'b0);
        end else if (b >= 8'hC0 && b < 8'hE0) begin
            seq_len = 2'd1;
            accum = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b < 8'hF0) begin
            seq_len = 2'd2;
            accum = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b < 8'hF5) begin
            seq_len = 2'd3;
            accum = {18'd0, b[2:0]};
        end else begin
            emit_point(ESC_BASE | {13'd0, b}, 1'b1);
        end
        if (b >= 8'hC0 && b < 8'hF5) begin
            cont_left = seq_len;
            held_seq[0] = b;
            held_n = 2'd1;
        end
    endfunction

    // failed sequence: escape the lead and every held continuation
    function automatic void abort_sequence();
        for (int i = 0; i < held_n; i++)
            emit_point(ESC_BASE | {13'd0, held_seq[i]}, 1'b1);
        clear_sequence();
    endfunction

    // expected results of one accepted transaction
    function automatic void decode_byte(input logic [7:0] b, input logic eoi);
        int          start_count;
        t_decoded    tail;
        logic [20:0] value;
        logic [20:0] floor_value;
        logic        rejected;
        start_count = pending_points.size();
        if (eoi) begin
            if (cont_left != 2'd0)
                abort_sequence();
        end else if (cont_left == 2'd0) begin
            open_or_emit(b);
        end else if (b[7:6] == 2'b10) begin
            accum = {accum[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                value = accum;
                case (seq_len)
                    2'd1:    floor_value = MIN_TWO;
                    2'd2:    floor_value = MIN_THREE;
                    default: floor_value = MIN_FOUR;
                endcase
                rejected = (value < floor_value) ||
                           (value[20:16] == 5'd0 && value[15:8] == ESC_BASE[15:8]) ||
                           (value > MAX_CODE);
                if (rejected) begin
                    abort_sequence();
                    open_or_emit(b);
                end else begin
                    emit_point(value, 1'b0);
                    clear_sequence();
                end
            end else if (held_n < 2'd3) begin
                held_seq[held_n] = b;
                held_n = held_n + 2'd1;
            end
        end else begin
            abort_sequence();
            open_or_emit(b);
        end
        // flag the final result of this transaction
        if (pending_points.size() > start_count) begin
            tail = pending_points.pop_back();
            tail.last_of_run = 1'b1;
            pending_points.push_back(tail);
        end
    endfunction

    // result side: check each popped transaction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result: code_point %h is_escape %b last_of_run %b",
                       o_code_point, o_is_escape, o_last_of_run);
                error_count++;
            end else begin
                oldest_point = pending_points.pop_front();
                if (o_code_point !== oldest_point.code_point) begin
                    $error("code_point: expected %h, got %h",
                           oldest_point.code_point, o_code_point);
                    error_count++;
                end
                if (o_is_escape !== oldest_point.is_escape) begin
                    $error("is_escape: expected %b, got %b",
                           oldest_point.is_escape, o_is_escape);
                    error_count++;
                end
                if (o_last_of_run !== oldest_point.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           oldest_point.last_of_run, o_last_of_run);
                    error_count++;
                end
            end
            pop_hold = steady ? 0 : $urandom_range(0, 3);
        end
        if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // send one byte or end mark, wait for the transaction
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_byte_value <= b;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(b, eoi);
    endtask

    // hold off the sender until every expected result has come
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ascii extremes and lone invalid bytes
    task automatic test_single_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        wait_for_drain();
    endtask

    // shortest two-byte form, largest code point, surrogate pass-through
    task automatic test_valid_sequences();
        send_item(8'hC2, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hF4, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hED, 1'b0);
        send_item(8'hA0, 1'b0);
        send_item(8'h80, 1'b0);
        wait_for_drain();
    endtask

    // four-byte lead cut by ascii: three escapes plus the byte itself
    task automatic test_broken_sequences();
        send_item(8'hF1, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h41, 1'b0);
        wait_for_drain();
    endtask

    // overlong, escape range and beyond the code space
    task automatic test_rejected_values();
        send_item(8'hC0, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hED, 1'b0);
        send_item(8'hB0, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hF4, 1'b0);
        send_item(8'h90, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h80, 1'b0);
        wait_for_drain();
    endtask

    // end mark when idle and inside a sequence
    task automatic test_end_of_input();
        send_item(8'hA5, 1'b1);
        send_item(8'hC5, 1'b0);
        send_item(8'h5A, 1'b1);
        wait_for_drain();
    endtask

    // random sequences: mostly well formed, some cut short, some noise
    task automatic random_burst(input int count);
        int         sent;
        int         kind;
        int         len;
        int         stop_at;
        logic [7:0] lead;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            len = $urandom_range(1, 4);
            case (len)
                1:       lead = 8'($urandom_range(8'h00, 8'h7F));
                2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
                3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                default: lead = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
            if (kind < 6) begin
                send_item(lead, 1'b0);
                for (int k = 1; k < len; k++)
                    send_item(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                sent += len;
            end else if (kind < 8 && len > 1) begin
                stop_at = $urandom_range(0, len - 2);
                send_item(lead, 1'b0);
                for (int k = 0; k < stop_at; k++)
                    send_item(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
                sent += stop_at + 2;
            end else begin
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_random_stream();
        steady = 1'b0;
        random_burst(30);
        wait_for_drain();
        steady = 1'b1;
        random_burst(20);
        steady = 1'b0;
        random_burst(20);
        wait_for_drain();
    endtask

    // test sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_bytes();
        test_valid_sequences();
        test_broken_sequences();
        test_rejected_values();
        test_end_of_input();
        test_random_stream();
        if (error_count == 0 && pending_points.size() == 0)
            $display("[utf8_stream_decoder] OK");
        else
            $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

endmodule
